FILE: design/cpusd_pkg.sv
`default_nettype none
package cpusd_pkg;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [3:0] CFG_POLICY  = 4'd0;
    localparam logic [3:0] CFG_QUANTUM = 4'd1;

    localparam int CLK_W = 20;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [CLK_W-1:0]   a;
        logic [CLK_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [CLK_W-1:0]   res;
        logic               borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] burst_time;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [4:0]       process_id;
        logic [CLK_W-1:0] slice_start;
        logic [15:0]      slice_length;
        logic             finished;
        logic [CLK_W-1:0] elapsed_time;
        logic             last;
    } t_res;

endpackage
`default_nettype wire

FILE: design/cpusd_alu.sv
`default_nettype none
module cpusd_alu
    import cpusd_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [CLK_W:0] w_sum;

    always_comb begin
        case (i_req.op)
            ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_sum = '0;
        endcase
    end

    // borrow on subtract means b > a
    assign o_rsp.res    = w_sum[CLK_W-1:0];
    assign o_rsp.borrow = w_sum[CLK_W];

endmodule
`default_nettype wire

FILE: design/cpu_scheduling_dispatcher.sv
`default_nettype none
// Channel   Ports                                      Handshake
// command   i_start, o_busy, i_cmd                     taken when i_start & !o_busy
// result    o_done, o_res                              one-cycle strobe, no backpressure
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,     taken when valid & ready
//           i_cfg_data
//
// Clear, rejected load, unused code, empty dispatch and FCFS/RR load: result in the cycle
// after the command. Dispatch: S_DRD, S_DFS, S_DCLK, then a finishing pass in S_IDLE,
// all through the shared add/subtract unit. SJF load: a read and a compare for each
// entry scanned, a read and a write for each entry shifted (registered queue read).
// Reset is synchronous, active low; no clearing pass. The result side cannot stall.
module cpu_scheduling_dispatcher
    import cpusd_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  t_cmd  i_cmd,
    output logic        o_done,
    output t_res        o_res,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [3:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int SW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    typedef struct packed {
        logic [SW-1:0] slot;
        logic [15:0]   rem;
    } t_qent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LRD,
        S_LCMP,
        S_SRD,
        S_SWR,
        S_DRD,
        S_DFS,
        S_DCLK
    } t_state;

    // D_EL folded: elapsed computed in S_IDLE while r_el is E_YES
    typedef enum logic {
        E_NO,
        E_YES
    } t_el;

    t_state              r_state, n_state;
    t_el                 r_el, n_el;
    logic [SW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_next, n_next;
    logic [CLK_W-1:0]    r_clock, n_clock;
    logic [MAX_PROCESSES-1:0] r_started, n_started;
    logic [1:0]          r_policy;
    logic [15:0]         r_quantum;
    logic                r_done, n_done;
    t_res                r_res, n_res;

    logic [15:0]         r_burst, n_burst;
    logic [SW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_ins, n_ins;
    logic [15:0]         r_rem, n_rem;
    logic                r_gt, n_gt;
    logic                r_was, n_was;
    logic                r_fin, n_fin;
    logic [CLK_W-1:0]    r_first, n_first;
    logic [CLK_W-1:0]    r_sstart, n_sstart;
    logic [15:0]         r_len, n_len;

    t_qent               q_mem [MAX_PROCESSES];
    t_qent               r_qrd;
    logic                q_we;
    logic [SW-1:0]       q_waddr, q_raddr;
    t_qent               q_wdata;

    logic [CLK_W-1:0]    fs_mem [MAX_PROCESSES];
    logic [CLK_W-1:0]    r_fsrd;
    logic                fs_we;
    logic [SW-1:0]       fs_waddr, fs_raddr;
    logic [CLK_W-1:0]    fs_wdata;

    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    logic [15:0]         w_q;
    logic                w_rr;
    logic [SW-1:0]       w_new_slot;

    cpusd_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    function automatic logic [SW-1:0] f_pos(input logic [SW-1:0] head,
                                            input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(x);
        if (s >= (CW+1)'(MAX_PROCESSES)) begin
            s = s - (CW+1)'(MAX_PROCESSES);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [4:0] f_id(input logic [SW-1:0] slot);
        return 5'(32'(slot) + 32'd1);
    endfunction

    assign w_q        = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign w_rr       = (r_policy == POL_RR);
    assign w_new_slot = r_next[SW-1:0];

    always_comb begin
        n_state   = r_state;
        n_el      = r_el;
        n_head    = r_head;
        n_count   = r_count;
        n_next    = r_next;
        n_clock   = r_clock;
        n_started = r_started;
        n_done    = 1'b0;
        n_res     = r_res;
        n_burst   = r_burst;
        n_slot    = r_slot;
        n_i       = r_i;
        n_ins     = r_ins;
        n_rem     = r_rem;
        n_gt      = r_gt;
        n_was     = r_was;
        n_fin     = r_fin;
        n_first   = r_first;
        n_sstart  = r_sstart;
        n_len     = r_len;
        q_we      = 1'b0;
        q_waddr   = f_pos(r_head, r_count);
        q_wdata   = '{slot: r_slot, rem: r_burst};
        q_raddr   = r_head;
        fs_we     = 1'b0;
        fs_waddr  = r_slot;
        fs_wdata  = r_clock;
        fs_raddr  = r_slot;
        alu_req   = '{op: ALU_ADD, a: '0, b: '0};

        case (r_state)
            S_IDLE: begin
                if (r_el == E_YES) begin
                    // finish a dispatch: clock already advanced
                    alu_req = '{op: ALU_SUB, a: r_clock, b: r_first};
                    n_res.status       = STAT_OK;
                    n_res.process_id   = f_id(r_slot);
                    n_res.slice_start  = r_sstart;
                    n_res.slice_length = r_len;
                    n_res.finished     = r_fin;
                    n_res.elapsed_time = w_rr ? (r_fin ? alu_rsp.res : '0) : r_sstart;
                    n_res.last         = (r_count == '0);
                    n_done = 1'b1;
                    n_el   = E_NO;
                end else if (i_start) begin
                    n_res = '0;
                    case (i_cmd.operation)
                        OP_CLEAR: begin
                            n_head    = '0;
                            n_count   = '0;
                            n_next    = '0;
                            n_clock   = '0;
                            n_started = '0;
                            n_done    = 1'b1;
                        end
                        OP_LOAD: begin
                            if (r_next >= CW'(MAX_PROCESSES)) begin
                                n_res.status = STAT_FULL;
                                n_done = 1'b1;
                            end else begin
                                n_next = r_next + CW'(1);
                                n_started[w_new_slot] = 1'b0;
                                n_burst = i_cmd.burst_time;
                                n_slot  = w_new_slot;
                                if (r_policy == POL_SJF) begin
                                    n_i     = '0;
                                    n_state = S_LRD;
                                end else begin
                                    q_we    = 1'b1;
                                    q_wdata = '{slot: w_new_slot, rem: i_cmd.burst_time};
                                    n_count = r_count + CW'(1);
                                    n_res.process_id = f_id(w_new_slot);
                                    n_done  = 1'b1;
                                end
                            end
                        end
                        OP_DISPATCH: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                                n_res.last   = 1'b1;
                                n_done = 1'b1;
                            end else begin
                                q_raddr = r_head;
                                n_state = S_DRD;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            // search for the first entry with a longer remaining time
            S_LRD: begin
                if (r_i == r_count) begin
                    n_ins   = r_count;
                    n_state = S_SRD;
                end else begin
                    q_raddr = f_pos(r_head, r_i);
                    n_state = S_LCMP;
                end
            end
            S_LCMP: begin
                alu_req = '{op: ALU_SUB, a: CLK_W'(r_burst), b: CLK_W'(r_qrd.rem)};
                if (alu_rsp.borrow) begin
                    n_ins   = r_i;
                    n_i     = r_count;
                    n_state = S_SRD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_LRD;
                end
            end
            // shift the tail back one place, then drop the new word in
            S_SRD: begin
                if (r_i == r_ins) begin
                    q_we    = 1'b1;
                    q_waddr = f_pos(r_head, r_ins);
                    n_count = r_count + CW'(1);
                    n_res   = '0;
                    n_res.process_id = f_id(r_slot);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    q_raddr = f_pos(r_head, r_i - CW'(1));
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                q_we    = 1'b1;
                q_waddr = f_pos(r_head, r_i);
                q_wdata = r_qrd;
                n_i     = r_i - CW'(1);
                n_state = S_SRD;
            end
            S_DRD: begin
                n_slot   = r_qrd.slot;
                n_rem    = r_qrd.rem;
                n_was    = r_started[r_qrd.slot];
                fs_raddr = r_qrd.slot;
                if (!r_started[r_qrd.slot]) begin
                    n_started[r_qrd.slot] = 1'b1;
                    fs_we    = 1'b1;
                    fs_waddr = r_qrd.slot;
                    n_first  = r_clock;
                end
                n_head  = f_pos(r_head, CW'(1));
                n_count = r_count - CW'(1);
                alu_req = '{op: ALU_SUB, a: CLK_W'(w_q), b: CLK_W'(r_qrd.rem)};
                n_gt    = alu_rsp.borrow;
                n_state = S_DFS;
            end
            S_DFS: begin
                if (r_was) begin
                    n_first = r_fsrd;
                end
                if (w_rr && r_gt) begin
                    alu_req = '{op: ALU_SUB, a: CLK_W'(r_rem), b: CLK_W'(w_q)};
                    n_len   = w_q;
                    n_fin   = 1'b0;
                    q_we    = 1'b1;
                    q_waddr = f_pos(r_head, r_count);
                    q_wdata = '{slot: r_slot, rem: alu_rsp.res[15:0]};
                    n_count = r_count + CW'(1);
                end else begin
                    n_len = r_rem;
                    n_fin = 1'b1;
                end
                n_state = S_DCLK;
            end
            S_DCLK: begin
                alu_req  = '{op: ALU_ADD, a: r_clock, b: CLK_W'(r_len)};
                n_clock  = alu_rsp.res;
                n_sstart = r_clock;
                n_el     = E_YES;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_burst  <= n_burst;
        r_slot   <= n_slot;
        r_i      <= n_i;
        r_ins    <= n_ins;
        r_rem    <= n_rem;
        r_gt     <= n_gt;
        r_was    <= n_was;
        r_fin    <= n_fin;
        r_first  <= n_first;
        r_sstart <= n_sstart;
        r_len    <= n_len;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_el      <= E_NO;
            r_head    <= '0;
            r_count   <= '0;
            r_next    <= '0;
            r_clock   <= '0;
            r_started <= '0;
            r_done    <= 1'b0;
            r_policy  <= POL_FCFS;
            r_quantum <= 16'd4;
        end else begin
            r_state   <= n_state;
            r_el      <= n_el;
            r_head    <= n_head;
            r_count   <= n_count;
            r_next    <= n_next;
            r_clock   <= n_clock;
            r_started <= n_started;
            r_done    <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POLICY:  r_policy  <= i_cfg_data[1:0];
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        r_qrd <= q_mem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        r_fsrd <= fs_mem[fs_raddr];
    end

    assign o_busy      = (r_state != S_IDLE) || (r_el == E_YES);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire
